@@ rtl/core/slh_pkg.sv @@
package slh_pkg;

    // default sizes
    localparam int NUM_CORES_DEF = 2;
    localparam int NUM_BINS_DEF  = 4096;

    // core field is one bit wide, so at most two cores are ever addressed
    localparam int CORE_SLOTS = 2;

    localparam logic [31:0] MAX_VALID_RESET = 32'd112500;
    localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;

    // operation codes
    localparam logic [1:0] OP_SWITCH_OUT = 2'd0;
    localparam logic [1:0] OP_SWITCH_IN  = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    // result kinds
    localparam logic KIND_OVERFLOW  = 1'b0;
    localparam logic KIND_BIN_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic        core;
        logic [63:0] timestamp;
        logic [11:0] bin_index;
    } event_item_t;

    typedef struct packed {
        logic        result_kind;
        logic        result_core;
        logic [31:0] result_value;
    } result_item_t;

endpackage

@@ rtl/core/switch_latency_histogram_top.sv @@
// channel | signals                                   | direction | item
// --------+-------------------------------------------+-----------+---------------------------
// event   | event_valid, event_ready, event_item      | in        | switch out / in, read+clear
// result  | result_valid, result_ready, result_item   | out       | overflow sample, bin count
// config  | cfg_we, cfg_data                          | in        | max_valid_latency write
//
// one item at a time: an item runs through subtract, filter, bin ram read and
// write back, and emit, skipping the steps its operation does not need; the
// next item is accepted only when it is done
// reset clears the timestamps at once, then a clearing pass writes zero to every
// bin, with event_ready low throughout
// a result waits in the output register; the next item is taken meanwhile and
// only stalls at its own emit step while result_ready stays low
module switch_latency_histogram_top
    import slh_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF,
    parameter int NUM_BINS  = NUM_BINS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         event_valid,
    output logic         event_ready,
    input  event_item_t  event_item,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_item,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data
);

    localparam int DEPTH  = NUM_CORES * NUM_BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(NUM_BINS);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_FILT  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [31:0]       max_lat_reg;

    // per-core last switch-out time, cleared by reset
    logic [63:0]       last_reg [CORE_SLOTS];

    // item being worked on
    logic [1:0]        op_reg;
    logic              core_reg;
    logic [63:0]       stamp_reg;
    logic [11:0]       bin_reg;
    logic [31:0]       lat_reg, lat_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [31:0]       value_reg, value_next;
    logic              kind_reg, kind_next;

    logic              res_valid_reg, res_valid_next;
    result_item_t      res_item_reg;

    // bin ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    logic              core_red;
    logic [63:0]       diff;
    logic [BIN_W-1:0]  idx;
    logic              emit_load;
    logic              accept;

    // core reduced modulo the core count
    assign core_red = (NUM_CORES > 1) ? event_item.core : 1'b0;
    assign accept   = event_valid && event_ready;
    assign event_ready = (state_reg == S_IDLE);

    assign diff = stamp_reg - last_reg[core_reg];

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        lat_next       = lat_reg;
        addr_next      = addr_reg;
        value_next     = value_reg;
        kind_next      = kind_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;
        idx            = lat_reg[BIN_W-1:0];
        emit_load      = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                // saturated latency of a switch in
                lat_next = (|diff[63:32]) ? SAT32 : diff[31:0];
                idx      = BIN_W'(bin_reg);
                addr_next = ADDR_W'(ADDR_W'(core_reg) * ADDR_W'(NUM_BINS)) + ADDR_W'(idx);
                unique case (op_reg)
                    OP_SWITCH_IN:
                    begin
                        state_next = S_FILT;
                    end
                    OP_READ_CLEAR:
                    begin
                        kind_next = KIND_BIN_COUNT;
                        if (32'(bin_reg) < 32'(NUM_BINS))
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = addr_next;
                            state_next = S_READ;
                        end
                        else
                        begin
                            // out-of-range bin reads as zero
                            value_next = '0;
                            state_next = S_EMIT;
                        end
                    end
                    default:
                    begin
                        // switch out is stored at the clock edge, unused code dropped
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILT:
            begin
                idx       = lat_reg[BIN_W-1:0];
                addr_next = ADDR_W'(ADDR_W'(core_reg) * ADDR_W'(NUM_BINS)) + ADDR_W'(idx);
                kind_next = KIND_OVERFLOW;
                if ((lat_reg == '0) || (lat_reg > max_lat_reg))
                begin
                    state_next = S_IDLE;
                end
                else if (lat_reg < 32'(NUM_BINS))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = addr_next;
                    state_next = S_READ;
                end
                else
                begin
                    value_next = lat_reg;
                    state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                if (op_reg == OP_SWITCH_IN)
                begin
                    // saturating increment
                    ram_wdata  = (ram_rdata == SAT32) ? ram_rdata : ram_rdata + 32'd1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_wdata  = '0;
                    value_next = ram_rdata;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    emit_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (emit_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
            max_lat_reg   <= MAX_VALID_RESET;
            for (int i = 0; i < CORE_SLOTS; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                max_lat_reg <= cfg_data;
            end
            if ((state_reg == S_CALC) && (op_reg == OP_SWITCH_OUT))
            begin
                last_reg[core_reg] <= stamp_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= event_item.operation;
            core_reg  <= core_red;
            stamp_reg <= event_item.timestamp;
            bin_reg   <= event_item.bin_index;
        end
        lat_reg   <= lat_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
        kind_reg  <= kind_next;
        if (emit_load)
        begin
            res_item_reg.result_kind  <= kind_reg;
            res_item_reg.result_core  <= core_reg;
            res_item_reg.result_value <= value_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

    // bin counters, one row per core
    slh_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

@@ rtl/core/slh_ram.sv @@
module slh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/slh_checker.sv @@
module slh_checker
    import slh_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF,
    parameter int NUM_BINS  = NUM_BINS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         event_valid,
    input logic         event_ready,
    input logic         result_valid,
    input logic         result_ready,
    input result_item_t result_item
);

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_ready |=> !event_ready)
        else $error("event accepted while previous item still in work");

    // overflow samples only carry latencies beyond the bins
    a_overflow_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_item.result_kind == KIND_OVERFLOW)
        |-> (result_item.result_value >= 32'(NUM_BINS)))
        else $error("overflow sample within bin range");

    // with a single core every result belongs to core zero
    a_core_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((NUM_CORES > 1) || !result_item.result_core))
        else $error("result core outside core count");

    // a waiting result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result dropped or changed while stalled");

endmodule

bind switch_latency_histogram_top slh_checker #(
    .NUM_CORES (NUM_CORES),
    .NUM_BINS  (NUM_BINS)
) u_slh_checker (.*);
